// ===== rtl/lphd_pkg.sv =====
`timescale 1ns / 1ps

package lphd_pkg;

    localparam int SAMPLE_W    = 24;
    localparam int ELAPSED_W   = 32;
    localparam int TIMER_W     = 33;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 4;

    localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [ELAPSED_W-1:0]       elapsed_t;
    typedef logic [TIMER_W-1:0]         timer_t;
    typedef logic [CFG_DATA_W-1:0]      cfg_data_t;
    typedef logic [CFG_INDEX_W-1:0]     cfg_index_t;

    localparam cfg_index_t REG_DECAY_RATE = 4'd0;
    localparam cfg_index_t REG_HOLD_DELAY = 4'd1;

    typedef struct packed {
        sample_t peak;
        timer_t  since_peak;
        logic    decaying;
    } state_t;

endpackage

// ===== rtl/lphd_update.sv =====
`timescale 1ns / 1ps

module lphd_update
(
    input  lphd_pkg::state_t    state_cur,
    input  lphd_pkg::cfg_data_t decay_rate,
    input  lphd_pkg::cfg_data_t hold_delay_us,
    input  lphd_pkg::sample_t   sample,
    input  lphd_pkg::elapsed_t  elapsed_us,
    output lphd_pkg::state_t    state_next
);

    logic [lphd_pkg::TIMER_W:0]          timer_sum;
    lphd_pkg::timer_t                    timer_sat;
    lphd_pkg::timer_t                    decay_time;
    logic                                apply;
    logic                                decaying_next;
    logic [2*lphd_pkg::CFG_DATA_W-1:0]   product;
    logic [lphd_pkg::CFG_DATA_W:0]       amount;
    logic signed [lphd_pkg::CFG_DATA_W+2:0] lowered;
    logic signed [lphd_pkg::CFG_DATA_W+2:0] sample_ext;

    always_comb
    begin
        timer_sum = {1'b0, state_cur.since_peak}
                  + {{(lphd_pkg::TIMER_W + 1 - lphd_pkg::ELAPSED_W){1'b0}}, elapsed_us};
        timer_sat = timer_sum[lphd_pkg::TIMER_W] ? lphd_pkg::TIMER_MAX
                                                 : timer_sum[lphd_pkg::TIMER_W-1:0];

        decay_time    = {{(lphd_pkg::TIMER_W - lphd_pkg::ELAPSED_W){1'b0}}, elapsed_us};
        apply         = 1'b0;
        decaying_next = state_cur.decaying;
        if (state_cur.decaying)
        begin
            apply = 1'b1;
        end
        else if (hold_delay_us != '0)
        begin
            // first item past the hold only decays by the overshoot
            if (timer_sat > {1'b0, hold_delay_us})
            begin
                decaying_next = 1'b1;
                decay_time    = timer_sat - {1'b0, hold_delay_us};
                apply         = 1'b1;
            end
        end
        else
        begin
            decaying_next = 1'b1;
            apply         = 1'b1;
        end

        // t is 33 bits: top bit contributes a whole rate, low word a 32x32 product
        product = decay_time[lphd_pkg::CFG_DATA_W-1:0] * decay_rate;
        amount  = {1'b0, product[2*lphd_pkg::CFG_DATA_W-1:lphd_pkg::CFG_DATA_W]}
                + (decay_time[lphd_pkg::TIMER_W-1] ? {1'b0, decay_rate}
                                                   : {(lphd_pkg::CFG_DATA_W+1){1'b0}});

        sample_ext = {{(lphd_pkg::CFG_DATA_W + 3 - lphd_pkg::SAMPLE_W){sample[lphd_pkg::SAMPLE_W-1]}},
                      sample};
        lowered = {{(lphd_pkg::CFG_DATA_W + 3 - lphd_pkg::SAMPLE_W)
                    {state_cur.peak[lphd_pkg::SAMPLE_W-1]}}, state_cur.peak}
                - $signed({2'b00, amount});
        if (lowered < sample_ext)
        begin
            lowered = sample_ext;
        end

        if (sample >= state_cur.peak)
        begin
            state_next.peak       = sample;
            state_next.since_peak = '0;
            state_next.decaying   = 1'b0;
        end
        else
        begin
            state_next.peak       = apply ? lowered[lphd_pkg::SAMPLE_W-1:0] : state_cur.peak;
            state_next.since_peak = timer_sat;
            state_next.decaying   = decaying_next;
        end
    end

endmodule

// ===== rtl/lossy_peak_hold_decay.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    sample, elapsed_us
// out       output     out_valid / out_ready  peak_out, is_decaying
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One request per cycle sustained while out_ready stays high; each result is
// valid once its request has passed the input register and then the
// combinational update into the held state and result register.
// rst_n clears the held peak, timer, decaying flag, config registers and all valids.
// A stalled result holds its register; one further request waits in the input
// register, after which in_ready drops until out_ready returns.

module lossy_peak_hold_decay
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    output logic                   in_ready,
    input  lphd_pkg::sample_t      sample,
    input  lphd_pkg::elapsed_t     elapsed_us,

    output logic                   out_valid,
    input  logic                   out_ready,
    output lphd_pkg::sample_t      peak_out,
    output logic                   is_decaying,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  lphd_pkg::cfg_index_t   cfg_index,
    input  lphd_pkg::cfg_data_t    cfg_data
);

    lphd_pkg::cfg_data_t  decay_rate_reg;
    lphd_pkg::cfg_data_t  hold_delay_reg;

    logic                 in_valid_reg;
    lphd_pkg::sample_t    sample_reg;
    lphd_pkg::elapsed_t   elapsed_reg;

    lphd_pkg::state_t     state_reg;
    lphd_pkg::state_t     state_next;

    logic                 out_valid_reg;
    logic                 advance;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign out_valid   = out_valid_reg;
    assign peak_out    = state_reg.peak;
    assign is_decaying = state_reg.decaying;

    lphd_update u_update
    (
        .state_cur     (state_reg),
        .decay_rate    (decay_rate_reg),
        .hold_delay_us (hold_delay_reg),
        .sample        (sample_reg),
        .elapsed_us    (elapsed_reg),
        .state_next    (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_rate_reg <= '0;
            hold_delay_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                lphd_pkg::REG_DECAY_RATE: decay_rate_reg <= cfg_data;
                lphd_pkg::REG_HOLD_DELAY: hold_delay_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            sample_reg  <= sample;
            elapsed_reg <= elapsed_us;
        end
    end

endmodule

// ===== rtl/lphd_checker.sv =====
`timescale 1ns / 1ps

module lphd_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               out_valid,
    input  logic               out_ready,
    input  lphd_pkg::sample_t  peak_out,
    input  logic               is_decaying
);

    // a result waiting for the sink keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(peak_out) && $stable(is_decaying))
    else $error("stalled result changed");

    assert property (@(posedge clk) !rst_n |-> !out_valid)
    else $error("result valid during reset");

    // a fresh result must be preceded by a taken request
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without request");

    // a draining output never blocks the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
    else $error("input stalled while output drains");

endmodule

bind lossy_peak_hold_decay lphd_checker u_lphd_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .peak_out    (peak_out),
    .is_decaying (is_decaying)
);

// ===== verif/lossy_peak_hold_decay_tb.sv =====
`timescale 1ns / 1ps

module lossy_peak_hold_decay_tb;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int TAIL_CYCLES     = 10;
    localparam int REPORT_MAX      = 10;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_ITEMS     = 80;

    localparam lphd_pkg::sample_t  SAMPLE_MIN = {1'b1, {(lphd_pkg::SAMPLE_W-1){1'b0}}};
    localparam lphd_pkg::sample_t  SAMPLE_MAX = {1'b0, {(lphd_pkg::SAMPLE_W-1){1'b1}}};
    localparam lphd_pkg::elapsed_t ELAPSED_MAX = {lphd_pkg::ELAPSED_W{1'b1}};
    localparam lphd_pkg::cfg_data_t CFG_MAX    = {lphd_pkg::CFG_DATA_W{1'b1}};

    typedef struct {
        lphd_pkg::sample_t  smp;
        lphd_pkg::elapsed_t el;
    } sample_item_t;

    typedef struct {
        lphd_pkg::sample_t peak;
        logic              decaying;
    } peak_result_t;

    logic       clk = 1'b0;
    logic       rst_n;

    logic                 in_valid = 1'b0;
    logic                 in_ready;
    lphd_pkg::sample_t    sample = '0;
    lphd_pkg::elapsed_t   elapsed_us = '0;

    logic                 out_valid;
    logic                 out_ready = 1'b0;
    lphd_pkg::sample_t    peak_out;
    logic                 is_decaying;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    lphd_pkg::cfg_index_t cfg_index = lphd_pkg::REG_DECAY_RATE;
    lphd_pkg::cfg_data_t  cfg_data = '0;

    // predictor state and its copy of the registers
    lphd_pkg::sample_t    model_peak = '0;
    lphd_pkg::timer_t     model_since = '0;
    logic                 model_decaying = 1'b0;
    lphd_pkg::cfg_data_t  model_rate = '0;
    lphd_pkg::cfg_data_t  model_hold = '0;

    sample_item_t pending_samples[$];
    peak_result_t expected_peaks[$];

    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int hold_off_req = 0;
    int hold_off_ack = 0;
    int hold_off_left = 0;
    int fail_count = 0;
    int report_count = 0;
    int quiet_cycles = 0;
    int gen_level = 0;

    lossy_peak_hold_decay dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .sample      (sample),
        .elapsed_us  (elapsed_us),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .peak_out    (peak_out),
        .is_decaying (is_decaying),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    function automatic peak_result_t advance_peak(lphd_pkg::sample_t smp,
                                                  lphd_pkg::elapsed_t el);
        logic [lphd_pkg::TIMER_W:0] sum;
        lphd_pkg::timer_t           t;
        logic [64:0]                prod;
        logic [32:0]                amt;
        longint                     nxt;
        logic                       apply;
        peak_result_t               r;
        sum = {1'b0, model_since} + {2'b00, el};
        model_since = (sum > {1'b0, lphd_pkg::TIMER_MAX}) ? lphd_pkg::TIMER_MAX
                                                          : sum[lphd_pkg::TIMER_W-1:0];
        t = {1'b0, el};
        apply = 1'b0;
        if (smp >= model_peak)
        begin
            model_peak = smp;
            model_decaying = 1'b0;
            model_since = '0;
        end
        else
        begin
            if (model_decaying)
                apply = 1'b1;
            else if (model_hold != '0)
            begin
                // hold must be strictly exceeded; only the overshoot decays
                if (model_since > {1'b0, model_hold})
                begin
                    model_decaying = 1'b1;
                    t = model_since - {1'b0, model_hold};
                    apply = 1'b1;
                end
            end
            else
            begin
                model_decaying = 1'b1;
                apply = 1'b1;
            end
            if (apply)
            begin
                prod = {32'b0, t} * {33'b0, model_rate};
                amt = prod[64:32];
                nxt = longint'(model_peak) - longint'(amt);
                if (nxt < longint'(smp))
                    nxt = longint'(smp);
                model_peak = lphd_pkg::sample_t'(nxt);
            end
        end
        r.peak = model_peak;
        r.decaying = model_decaying;
        return r;
    endfunction

    // driver
    always @(posedge clk)
    begin
        logic         fire;
        sample_item_t it;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            fire = in_valid && in_ready;
            if (fire)
                expected_peaks.push_back(advance_peak(sample, elapsed_us));
            if (!in_valid || fire)
            begin
                if (pending_samples.size() > 0 && $urandom_range(0, 99) >= send_gap_pct)
                begin
                    it = pending_samples.pop_front();
                    in_valid <= 1'b1;
                    sample <= it.smp;
                    elapsed_us <= it.el;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver; a long hold-off is counted here when requested
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (hold_off_req != hold_off_ack)
            begin
                hold_off_ack = hold_off_req;
                hold_off_left = HOLD_OFF_CYCLES;
            end
            if (hold_off_left > 0)
            begin
                hold_off_left = hold_off_left - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        peak_result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_peaks.size() == 0)
            begin
                fail_count++;
                if (report_count < REPORT_MAX)
                    $display("unexpected result: peak %0d decaying %0b", peak_out, is_decaying);
                report_count++;
            end
            else
            begin
                e = expected_peaks.pop_front();
                if (peak_out !== e.peak || is_decaying !== e.decaying)
                begin
                    fail_count++;
                    if (report_count < REPORT_MAX)
                        $display(
                            "mismatch: expected peak %0d decaying %0b, got peak %0d decaying %0b",
                            e.peak, e.decaying, peak_out, is_decaying);
                    report_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic write_reg(lphd_pkg::cfg_index_t idx, lphd_pkg::cfg_data_t val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            lphd_pkg::REG_DECAY_RATE: model_rate = val;
            lphd_pkg::REG_HOLD_DELAY: model_hold = val;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_samples.size() != 0 || in_valid || expected_peaks.size() != 0);
    endtask

    task automatic queue_sample(lphd_pkg::sample_t smp, lphd_pkg::elapsed_t el);
        sample_item_t it;
        it.smp = smp;
        it.el = el;
        pending_samples.push_back(it);
    endtask

    task automatic queue_random_sample();
        int                 kind;
        int                 v;
        lphd_pkg::elapsed_t el;
        lphd_pkg::sample_t  smp;
        kind = $urandom_range(0, 99);
        if (kind < 10)
            smp = lphd_pkg::sample_t'($urandom);
        else if (kind < 14)
        begin
            case ($urandom_range(0, 2))
                0: smp = SAMPLE_MIN;
                1: smp = SAMPLE_MAX;
                default: smp = '0;
            endcase
        end
        else if (kind < 22)
        begin
            gen_level = int'(lphd_pkg::sample_t'($urandom));
            smp = lphd_pkg::sample_t'(gen_level);
        end
        else if (kind < 30)
        begin
            gen_level = gen_level + $urandom_range(1, 4096);
            if (gen_level > int'(SAMPLE_MAX))
                gen_level = int'(SAMPLE_MAX);
            smp = lphd_pkg::sample_t'(gen_level);
        end
        else
        begin
            // just below the running level, so hold and decay get exercised
            v = gen_level - $urandom_range(0, 1 << $urandom_range(0, 20));
            if (v < int'(SAMPLE_MIN))
                v = int'(SAMPLE_MIN);
            smp = lphd_pkg::sample_t'(v);
        end
        kind = $urandom_range(0, 99);
        if (kind < 10)
            el = '0;
        else if (kind < 40)
            el = $urandom_range(1, 16);
        else if (kind < 70)
            el = $urandom_range(0, 2000);
        else if (kind < 85)
            el = $urandom_range(0, 1000000);
        else if (kind < 97)
            el = $urandom;
        else
            el = ELAPSED_MAX;
        queue_sample(smp, el);
    endtask

    initial
    begin
        int                  ph;
        lphd_pkg::cfg_data_t rate;
        lphd_pkg::cfg_data_t hold;
        rst_n <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset registers: zero rate, no hold
        queue_sample(-24'sd1, 32'd10);
        wait_idle();

        write_reg(lphd_pkg::REG_DECAY_RATE, 32'h8000_0000);
        write_reg(lphd_pkg::REG_HOLD_DELAY, 32'd100);
        @(negedge clk);
        queue_sample(24'sd1000, 32'd0);
        queue_sample(24'sd500, 32'd50);
        queue_sample(24'sd500, 32'd50);      // timer equals hold: still held
        queue_sample(24'sd500, 32'd10);      // expires, only overshoot decays
        queue_sample(24'sd500, 32'd3);       // half-LSB rate, floor
        queue_sample(24'sd500, 32'd1);
        queue_sample(SAMPLE_MAX, 32'd7);
        queue_sample(SAMPLE_MAX, 32'd0);     // equal sample restarts the hold
        queue_sample(SAMPLE_MIN, 32'd20);
        queue_sample(24'sd0, 32'd5);
        wait_idle();

        write_reg(lphd_pkg::REG_HOLD_DELAY, '0);
        write_reg(lphd_pkg::REG_DECAY_RATE, CFG_MAX);
        @(negedge clk);
        queue_sample(24'sd100, 32'd0);
        queue_sample(SAMPLE_MIN, ELAPSED_MAX);  // huge decay clamps at sample
        queue_sample(SAMPLE_MIN, 32'd1);
        queue_sample(24'sd100, 32'd0);
        wait_idle();

        write_reg(lphd_pkg::REG_HOLD_DELAY, CFG_MAX);
        write_reg(lphd_pkg::REG_DECAY_RATE, 32'h0000_0100);
        @(negedge clk);
        // timer saturates on the third long gap
        repeat (4) queue_sample(24'sd0, ELAPSED_MAX);
        wait_idle();

        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0: begin rate = '0;      hold = '0;      end
                1: begin rate = CFG_MAX; hold = CFG_MAX; end
                2: begin rate = CFG_MAX; hold = '0;      end
                3: begin rate = '0;      hold = CFG_MAX; end
                default:
                begin
                    rate = $urandom >> $urandom_range(0, 31);
                    hold = ($urandom_range(0, 3) == 0)
                         ? lphd_pkg::cfg_data_t'($urandom)
                         : lphd_pkg::cfg_data_t'($urandom_range(0, 3000));
                end
            endcase
            write_reg(lphd_pkg::REG_DECAY_RATE, rate);
            write_reg(lphd_pkg::REG_HOLD_DELAY, hold);
            @(negedge clk);
            case ((ph == 5) ? 0 : ph % 4)
                0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_gap_pct = 54; recv_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  recv_stall_pct = 54; end
                default: begin send_gap_pct = 12; recv_stall_pct = 12; end
            endcase
            // back-pressure: output held off while input keeps offering
            if (ph == 5)
                hold_off_req++;
            repeat (PHASE_ITEMS) queue_random_sample();
            wait_idle();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && expected_peaks.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
